// ===== rtl/ffps_pkg.sv =====
// Shared types, widths, constants, microcode word format and step codes for the padded size unit.
package ffps_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CIRC_W     = COUNT_BITS + 1;
    localparam int DFT_W      = COUNT_BITS + 2;

    localparam longint unsigned DFT_MAX = (64'd1 << DFT_W) - 64'd1;

    // Modular inverse of an odd constant modulo 2^64 by Newton iteration.
    function automatic longint unsigned inv_mod(input longint unsigned d);
        longint unsigned x;
        x = d;
        for (int k = 0; k < 6; k++) begin
            x = x * (64'd2 - d * x);
        end
        return x;
    endfunction

    // Exact division by an odd constant: q = n * inv (mod 2^DFT_W), and n is
    // divisible exactly when q does not exceed floor((2^DFT_W - 1) / d).
    localparam logic [DFT_W-1:0] INV3 = DFT_W'(inv_mod(64'd3));
    localparam logic [DFT_W-1:0] INV5 = DFT_W'(inv_mod(64'd5));
    localparam logic [DFT_W-1:0] INV7 = DFT_W'(inv_mod(64'd7));
    localparam logic [DFT_W-1:0] LIM3 = DFT_W'(DFT_MAX / 64'd3);
    localparam logic [DFT_W-1:0] LIM5 = DFT_W'(DFT_MAX / 64'd5);
    localparam logic [DFT_W-1:0] LIM7 = DFT_W'(DFT_MAX / 64'd7);

    localparam logic [DFT_W-1:0] RESIDUE_ONE      = DFT_W'(1);
    localparam logic [DFT_W-1:0] RESIDUE_ELEVEN   = DFT_W'(11);
    localparam logic [DFT_W-1:0] RESIDUE_THIRTEEN = DFT_W'(13);

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_DIV,
        OP_CHECK,
        OP_DONE
    } t_op;

    typedef enum logic [1:0] {
        DIV_2,
        DIV_3,
        DIV_5,
        DIV_7
    } t_div;

    typedef logic [2:0] t_step;

    localparam t_step STEP_LOAD  = 3'd0;
    localparam t_step STEP_DIV2  = 3'd1;
    localparam t_step STEP_DIV3  = 3'd2;
    localparam t_step STEP_DIV5  = 3'd3;
    localparam t_step STEP_DIV7  = 3'd4;
    localparam t_step STEP_CHECK = 3'd5;
    localparam t_step STEP_DONE  = 3'd6;

    // One control word: the operation, the divisor, the target taken when
    // the step's condition holds, and the next step otherwise.
    typedef struct packed {
        t_op   op;
        t_div  sel;
        t_step jump;
        t_step next;
    } t_uword;

    typedef struct packed {
        logic load;
        t_op  op;
        t_div sel;
    } t_dp_ctrl;

    typedef struct packed {
        logic hit;
        logic friendly;
    } t_dp_stat;

endpackage

// ===== rtl/fft_friendly_padded_size_unit.sv =====
// Top level: microcode sequencer, datapath and output register of the padded size unit.
// Each candidate length is loaded, divided by 2, 3, 5 and 7 as often as each divides
// it, then checked; the search starts at 2*site_count-1 and ends at or below the
// next power of two. The result is held in an output register.
// One item is in the datapath at a time; the next is taken as soon as the result
// moves to the output register. Synchronous active-low reset clears control state.
module fft_friendly_padded_size_unit
    import ffps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COUNT_BITS-1:0] i_site_count,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CIRC_W-1:0]     o_circulant_len,
    output logic [DFT_W-1:0]      o_dft_len,
    output logic [CIRC_W-1:0]     o_zero_fill
);

    logic              r_busy;
    t_step             r_step;
    logic              r_out_valid;
    logic [CIRC_W-1:0] r_circulant_len;
    logic [DFT_W-1:0]  r_dft_len;
    logic [CIRC_W-1:0] r_zero_fill;

    t_uword            uword;
    t_dp_ctrl          ctrl;
    t_dp_stat          stat;
    logic [CIRC_W-1:0] circ;
    logic [DFT_W-1:0]  cand;
    logic              in_xfer;
    logic              out_free;
    logic              cond;
    logic              done_load;
    logic [DFT_W-1:0]  fill_full;

    ffps_ucode u_ucode (
        .i_step (r_step),
        .o_word (uword)
    );

    ffps_datapath u_datapath (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .i_site_count (i_site_count),
        .o_stat       (stat),
        .o_circ       (circ),
        .o_cand       (cand)
    );

    assign o_ready  = ~r_busy;
    assign in_xfer  = i_valid & o_ready;
    assign out_free = ~r_out_valid | i_ready;

    // A finished search moves its result to the output register.
    assign done_load = r_busy & (uword.op == OP_DONE) & out_free;

    // Idle cycles issue a no-operation word to the datapath, apart from the load of a new count.
    assign ctrl.load = in_xfer;
    assign ctrl.op   = r_busy ? uword.op : OP_DONE;
    assign ctrl.sel  = uword.sel;

    assign cond = (uword.op == OP_DIV) ? stat.hit : stat.friendly;

    assign fill_full = cand - {1'b0, circ};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            if (done_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer) begin
                r_busy <= 1'b1;
                r_step <= STEP_LOAD;
            end else if (r_busy) begin
                unique case (uword.op)
                    OP_LOAD: r_step <= uword.next;
                    OP_DIV, OP_CHECK: r_step <= cond ? uword.jump : uword.next;
                    OP_DONE: begin
                        // Hold here until the output register can take the result.
                        if (out_free) begin
                            r_circulant_len <= circ;
                            r_dft_len       <= cand;
                            r_zero_fill     <= fill_full[CIRC_W-1:0];
                            r_busy          <= 1'b0;
                            r_step          <= uword.next;
                        end
                    end
                    default: r_step <= STEP_LOAD;
                endcase
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_circulant_len = r_circulant_len;
    assign o_dft_len       = r_dft_len;
    assign o_zero_fill     = r_zero_fill;

`ifndef SYNTHESIS
    a_start_at_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_busy && r_step == STEP_LOAD))
        else $error("search did not start at the first step");

    a_cand_not_below_circ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step != STEP_LOAD) |-> (cand >= {1'b0, circ}))
        else $error("candidate fell below the circulant length");

    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dft_len >= {1'b0, o_circulant_len}))
        else $error("transform length below circulant length");

    a_fill_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_zero_fill} == o_dft_len - {1'b0, o_circulant_len}))
        else $error("zero fill does not match the two lengths");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && uword.op == OP_DONE && out_free && !in_xfer) |=> (o_valid && !r_busy))
        else $error("finished result was not transferred to the output register");
`endif

endmodule

// ===== rtl/ffps_ucode.sv =====
// Microcode table of the padded size search.
module ffps_ucode
    import ffps_pkg::*;
(
    input  t_step  i_step,
    output t_uword o_word
);

    always_comb begin
        unique case (i_step)
            STEP_LOAD:  o_word = '{OP_LOAD,  DIV_2, STEP_DIV2,  STEP_DIV2};
            STEP_DIV2:  o_word = '{OP_DIV,   DIV_2, STEP_DIV2,  STEP_DIV3};
            STEP_DIV3:  o_word = '{OP_DIV,   DIV_3, STEP_DIV3,  STEP_DIV5};
            STEP_DIV5:  o_word = '{OP_DIV,   DIV_5, STEP_DIV5,  STEP_DIV7};
            STEP_DIV7:  o_word = '{OP_DIV,   DIV_7, STEP_DIV7,  STEP_CHECK};
            // A friendly residue ends the search; otherwise try the next length.
            STEP_CHECK: o_word = '{OP_CHECK, DIV_2, STEP_DONE,  STEP_LOAD};
            STEP_DONE:  o_word = '{OP_DONE,  DIV_2, STEP_LOAD,  STEP_LOAD};
            default:    o_word = '{OP_DONE,  DIV_2, STEP_LOAD,  STEP_LOAD};
        endcase
    end

endmodule

// ===== rtl/ffps_datapath.sv =====
// Candidate, residue and circulant length registers with the factor divider.
module ffps_datapath
    import ffps_pkg::*;
(
    input  logic                  i_clk,
    input  t_dp_ctrl              i_ctrl,
    input  logic [COUNT_BITS-1:0] i_site_count,
    output t_dp_stat              o_stat,
    output logic [CIRC_W-1:0]     o_circ,
    output logic [DFT_W-1:0]      o_cand
);

    logic [CIRC_W-1:0]     r_circ;
    logic [DFT_W-1:0]      r_cand;
    logic [DFT_W-1:0]      r_work;
    logic [COUNT_BITS-1:0] site;
    logic [CIRC_W-1:0]     circ;
    logic [DFT_W-1:0]      inv;
    logic [DFT_W-1:0]      lim;
    logic [DFT_W-1:0]      prod;
    logic [DFT_W-1:0]      quot;
    logic                  hit;

    // A count of zero is handled as a single site.
    assign site = (i_site_count == '0) ? COUNT_BITS'(1) : i_site_count;
    assign circ = {site, 1'b0} - CIRC_W'(1);

    always_comb begin
        unique case (i_ctrl.sel)
            DIV_3:   begin inv = INV3; lim = LIM3; end
            DIV_5:   begin inv = INV5; lim = LIM5; end
            DIV_7:   begin inv = INV7; lim = LIM7; end
            default: begin inv = INV3; lim = LIM3; end
        endcase
    end

    assign prod = r_work * inv;

    always_comb begin
        if (i_ctrl.sel == DIV_2) begin
            hit  = ~r_work[0];
            quot = r_work >> 1;
        end else begin
            hit  = (prod <= lim);
            quot = prod;
        end
    end

    assign o_stat.hit      = hit;
    assign o_stat.friendly = (r_work == RESIDUE_ONE) || (r_work == RESIDUE_ELEVEN)
                             || (r_work == RESIDUE_THIRTEEN);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_circ <= circ;
            r_cand <= {1'b0, circ};
        end else begin
            unique case (i_ctrl.op)
                OP_LOAD: r_work <= r_cand;
                OP_DIV: begin
                    if (hit) begin
                        r_work <= quot;
                    end
                end
                OP_CHECK: begin
                    if (!o_stat.friendly) begin
                        r_cand <= r_cand + DFT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_circ = r_circ;
    assign o_cand = r_cand;

endmodule
